// ===== src/abfb_pkg.sv =====
package abfb_pkg;

   localparam int DEF_MAX_WIDTH  = 256;
   localparam int DEF_MAX_HEIGHT = 256;

   localparam int OP_W        = 3;
   localparam int COORD_W     = 16;
   localparam int PIXEL_W     = 32;
   localparam int DIM_W       = 9;
   localparam int CSR_INDEX_W = 1;
   localparam int CHAN_W      = 8;

   // largest size that a 9-bit register can ask for
   localparam int DIM_CAP = 511;

   localparam logic [DIM_W-1:0] RESET_DIM = 9'd256;

   localparam logic [OP_W-1:0] OP_WRITE     = 3'd0;
   localparam logic [OP_W-1:0] OP_BLEND     = 3'd1;
   localparam logic [OP_W-1:0] OP_READ      = 3'd2;
   localparam logic [OP_W-1:0] OP_FILL_ALL  = 3'd3;
   localparam logic [OP_W-1:0] OP_FILL_RECT = 3'd4;

   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'd1;

   // floor(s / 255) == (s * 32897) >> 23 for every s up to 255 * 255
   localparam logic [15:0] RECIP_255   = 16'd32897;
   localparam int          RECIP_SHIFT = 23;

   typedef enum logic [2:0] {
      KIND_NOP,
      KIND_WRITE,
      KIND_BLEND,
      KIND_READ,
      KIND_FILL
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic               hit;
      logic [PIXEL_W-1:0] pixel;
      logic [DIM_W-1:0]   x0;
      logic [DIM_W-1:0]   x1;
      logic [DIM_W-1:0]   y0;
      logic [DIM_W-1:0]   y1;
      logic [DIM_W-1:0]   stride;
   } cmd_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EXEC,
      ST_BLEND,
      ST_FILL,
      ST_HOLD
   } back_state_type;

endpackage

// ===== src/abfb_front.sv =====
module abfb_front #(
   parameter int MAX_WIDTH  = abfb_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = abfb_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [abfb_pkg::OP_W-1:0]              req_op,
   input  logic signed [abfb_pkg::COORD_W-1:0]    req_x_pos,
   input  logic signed [abfb_pkg::COORD_W-1:0]    req_y_pos,
   input  logic signed [abfb_pkg::COORD_W-1:0]    req_x_end,
   input  logic signed [abfb_pkg::COORD_W-1:0]    req_y_end,
   input  logic [abfb_pkg::PIXEL_W-1:0]           req_pixel_in,
   input  logic                                   csr_we,
   input  logic [abfb_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [abfb_pkg::DIM_W-1:0]             csr_wdata,
   input  logic                                   q_full,
   input  logic                                   clearing,
   output logic                                   push,
   output abfb_pkg::cmd_type                      cmd
);
   import abfb_pkg::*;

   localparam int W_CAP = (MAX_WIDTH < DIM_CAP) ? MAX_WIDTH : DIM_CAP;
   localparam int H_CAP = (MAX_HEIGHT < DIM_CAP) ? MAX_HEIGHT : DIM_CAP;

   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   logic [DIM_W-1:0] eff_w, eff_h;

   logic signed [COORD_W:0] xs, ys, xes, yes, ws, hs, wm1, hm1;
   logic signed [COORD_W:0] x0s, y0s, x1s, y1s;
   logic                    in_image, rect_hit, all_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_DIM;
         height_ff <= RESET_DIM;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_we) begin
         case (csr_index)
            REG_IMAGE_WIDTH:  width_in  = csr_wdata;
            REG_IMAGE_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   assign eff_w = (width_ff > DIM_W'(W_CAP)) ? DIM_W'(W_CAP) : width_ff;
   assign eff_h = (height_ff > DIM_W'(H_CAP)) ? DIM_W'(H_CAP) : height_ff;

   assign req_stall = q_full | clearing;
   assign push      = req_valid & ~req_stall;

   always_comb begin
      xs  = (COORD_W+1)'(req_x_pos);
      ys  = (COORD_W+1)'(req_y_pos);
      xes = (COORD_W+1)'(req_x_end);
      yes = (COORD_W+1)'(req_y_end);
      ws  = $signed({{(COORD_W+1-DIM_W){1'b0}}, eff_w});
      hs  = $signed({{(COORD_W+1-DIM_W){1'b0}}, eff_h});
      wm1 = ws - 17'sd1;
      hm1 = hs - 17'sd1;

      in_image = (xs >= 17'sd0) && (ys >= 17'sd0) && (xs < ws) && (ys < hs);

      // clip the rectangle to the image
      x0s = (xs < 17'sd0) ? 17'sd0 : xs;
      y0s = (ys < 17'sd0) ? 17'sd0 : ys;
      x1s = (xes < wm1) ? xes : wm1;
      y1s = (yes < hm1) ? yes : hm1;
      rect_hit = (x0s <= x1s) && (y0s <= y1s);
      all_hit  = (eff_w != '0) && (eff_h != '0);

      cmd.kind   = KIND_NOP;
      cmd.hit    = 1'b0;
      cmd.pixel  = req_pixel_in;
      cmd.x0     = xs[DIM_W-1:0];
      cmd.x1     = xs[DIM_W-1:0];
      cmd.y0     = ys[DIM_W-1:0];
      cmd.y1     = ys[DIM_W-1:0];
      cmd.stride = eff_w;

      case (req_op)
         OP_WRITE: begin
            cmd.kind = KIND_WRITE;
            cmd.hit  = in_image;
         end
         OP_BLEND: begin
            cmd.kind = KIND_BLEND;
            cmd.hit  = in_image;
         end
         OP_READ: begin
            cmd.kind = KIND_READ;
            cmd.hit  = in_image;
         end
         OP_FILL_ALL: begin
            cmd.kind = KIND_FILL;
            cmd.hit  = all_hit;
            cmd.x0   = '0;
            cmd.y0   = '0;
            cmd.x1   = wm1[DIM_W-1:0];
            cmd.y1   = hm1[DIM_W-1:0];
         end
         OP_FILL_RECT: begin
            cmd.kind = KIND_FILL;
            cmd.hit  = rect_hit;
            cmd.x0   = x0s[DIM_W-1:0];
            cmd.y0   = y0s[DIM_W-1:0];
            cmd.x1   = x1s[DIM_W-1:0];
            cmd.y1   = y1s[DIM_W-1:0];
         end
         default: ;
      endcase
   end

endmodule

// ===== src/abfb_queue.sv =====
module abfb_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  abfb_pkg::cmd_type push_cmd,
   input  logic              pop,
   output logic              q_valid,
   output logic              q_full,
   output abfb_pkg::cmd_type q_cmd
);
   import abfb_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   assign q_valid = (count_ff != 2'd0);
   assign q_full  = (count_ff == 2'd2);
   assign q_cmd   = slot_ff[rd_ptr_ff];

endmodule

// ===== src/abfb_back.sv =====
module abfb_back #(
   parameter int MAX_WIDTH  = abfb_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = abfb_pkg::DEF_MAX_HEIGHT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           q_valid,
   input  abfb_pkg::cmd_type              q_cmd,
   output logic                           pop,
   output logic                           clearing,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [abfb_pkg::PIXEL_W-1:0]   rsp_pixel_out,
   output logic                           rsp_in_range
);
   import abfb_pkg::*;

   localparam int W_CAP  = (MAX_WIDTH < DIM_CAP) ? MAX_WIDTH : DIM_CAP;
   localparam int H_CAP  = (MAX_HEIGHT < DIM_CAP) ? MAX_HEIGHT : DIM_CAP;
   localparam int DEPTH  = W_CAP * H_CAP;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int LIN_W  = 2 * DIM_W;

   logic [PIXEL_W-1:0] mem [DEPTH];
   logic [PIXEL_W-1:0] rd_data_ff;

   back_state_type state_ff, state_in;
   cmd_type        work_ff, work_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [ADDR_W-1:0] row_ff, row_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [DIM_W-1:0]  xc_ff, xc_in;
   logic [DIM_W-1:0]  yc_ff, yc_in;
   logic [15:0]       sum_ff [3];
   logic [15:0]       sum_in [3];

   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0] rsp_pixel_ff, rsp_pixel_in;
   logic               rsp_inr_ff, rsp_inr_in;
   logic [PIXEL_W-1:0] hold_pixel_ff, hold_pixel_in;
   logic               hold_inr_ff, hold_inr_in;

   logic               mem_we, mem_re;
   logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
   logic [PIXEL_W-1:0] mem_wdata;

   logic               fin;
   logic [PIXEL_W-1:0] fin_pixel;
   logic               fin_inr;
   logic               out_free;
   logic [LIN_W-1:0]   head_lin, next_row;
   logic [PIXEL_W-1:0] blended;
   logic [31:0]        quot [3];
   logic [15:0]        prod_b, prod_f;
   logic [CHAN_W-1:0]  alpha_f, alpha_b;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      work_ff       <= work_in;
      addr_ff       <= addr_in;
      row_ff        <= row_in;
      xc_ff         <= xc_in;
      yc_ff         <= yc_in;
      sum_ff        <= sum_in;
      rsp_pixel_ff  <= rsp_pixel_in;
      rsp_inr_ff    <= rsp_inr_in;
      hold_pixel_ff <= hold_pixel_in;
      hold_inr_ff   <= hold_inr_in;
   end

   assign out_free = ~rsp_valid_ff | ~rsp_stall;
   assign head_lin = LIN_W'(q_cmd.y0) * LIN_W'(q_cmd.stride) + LIN_W'(q_cmd.x0);
   assign next_row = LIN_W'(row_ff) + LIN_W'(work_ff.stride);
   assign alpha_f  = work_ff.pixel[PIXEL_W-1 -: CHAN_W];
   assign alpha_b  = rd_data_ff[PIXEL_W-1 -: CHAN_W];

   // per-channel divide by 255 as a reciprocal multiply
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         quot[c] = 32'(sum_ff[c]) * 32'(RECIP_255);
         blended[c*CHAN_W +: CHAN_W] = quot[c][RECIP_SHIFT +: CHAN_W];
      end
      blended[PIXEL_W-1 -: CHAN_W] = (alpha_b > alpha_f) ? alpha_b : alpha_f;
   end

   always_comb begin
      state_in      = state_ff;
      work_in       = work_ff;
      addr_in       = addr_ff;
      row_in        = row_ff;
      clr_in        = clr_ff;
      xc_in         = xc_ff;
      yc_in         = yc_ff;
      sum_in        = sum_ff;
      hold_pixel_in = hold_pixel_ff;
      hold_inr_in   = hold_inr_ff;
      rsp_pixel_in  = rsp_pixel_ff;
      rsp_inr_in    = rsp_inr_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      pop           = 1'b0;
      clearing      = 1'b0;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = addr_ff;
      mem_raddr     = head_lin[ADDR_W-1:0];
      mem_wdata     = work_ff.pixel;
      fin           = 1'b0;
      fin_pixel     = '0;
      fin_inr       = 1'b0;
      prod_b        = '0;
      prod_f        = '0;

      case (state_ff)
         ST_CLEAR: begin
            clearing  = 1'b1;
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = clr_ff + 1'b1;
            if (clr_ff == ADDR_W'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               pop      = 1'b1;
               mem_re   = 1'b1;
               work_in  = q_cmd;
               addr_in  = head_lin[ADDR_W-1:0];
               row_in   = head_lin[ADDR_W-1:0];
               xc_in    = q_cmd.x0;
               yc_in    = q_cmd.y0;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (work_ff.kind)
               KIND_WRITE: begin
                  mem_we  = work_ff.hit;
                  fin     = 1'b1;
                  fin_inr = work_ff.hit;
               end
               KIND_READ: begin
                  fin       = 1'b1;
                  fin_inr   = work_ff.hit;
                  fin_pixel = work_ff.hit ? rd_data_ff : '0;
               end
               KIND_BLEND: begin
                  if (work_ff.hit) begin
                     for (int c = 0; c < 3; c++) begin
                        prod_b = 16'(rd_data_ff[c*CHAN_W +: CHAN_W])
                               * 16'(8'd255 - alpha_f);
                        prod_f = 16'(work_ff.pixel[c*CHAN_W +: CHAN_W]) * 16'(alpha_f);
                        sum_in[c] = prod_b + prod_f;
                     end
                     state_in = ST_BLEND;
                  end else begin
                     fin = 1'b1;
                  end
               end
               KIND_FILL: begin
                  if (work_ff.hit) begin
                     state_in = ST_FILL;
                  end else begin
                     fin = 1'b1;
                  end
               end
               default: begin
                  fin = 1'b1;
               end
            endcase
         end
         ST_BLEND: begin
            mem_we    = 1'b1;
            mem_wdata = blended;
            fin       = 1'b1;
            fin_inr   = 1'b1;
         end
         ST_FILL: begin
            mem_we = 1'b1;
            if (xc_ff == work_ff.x1 && yc_ff == work_ff.y1) begin
               fin = 1'b1;
            end else if (xc_ff == work_ff.x1) begin
               xc_in   = work_ff.x0;
               yc_in   = yc_ff + 1'b1;
               row_in  = next_row[ADDR_W-1:0];
               addr_in = next_row[ADDR_W-1:0];
            end else begin
               xc_in   = xc_ff + 1'b1;
               addr_in = addr_ff + 1'b1;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pixel_in = hold_pixel_ff;
               rsp_inr_in   = hold_inr_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // result goes straight out when the output register frees up, else parks
      if (fin) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            rsp_pixel_in = fin_pixel;
            rsp_inr_in   = fin_inr;
            state_in     = ST_IDLE;
         end else begin
            hold_pixel_in = fin_pixel;
            hold_inr_in   = fin_inr;
            state_in      = ST_HOLD;
         end
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;
   assign rsp_in_range  = rsp_inr_ff;

endmodule

// ===== src/alpha_blend_framebuffer_unit.sv =====
// RGBA pixel store with write, alpha blend, read, fill-all and clipped rectangle fill.
// After reset the pixel memory is swept to zero one word per cycle, covering
// min(MAX_WIDTH,511) * min(MAX_HEIGHT,511) words (65536 at the defaults); req_stall
// stays high during that sweep, while csr writes are taken as usual. A front stage
// checks bounds and clips rectangles, and a two-entry command queue feeds the
// execution stage, which owns the single-port-write, registered-read memory. Write,
// read and unused codes complete in the execution state, a blend steps through
// read, multiply, divide-by-255 and write back, and a fill writes its covered pixels
// one after another through the single memory write port. One result is
// returned per transfer on the rsp channel; pixel_out is zero except for reads.
module alpha_blend_framebuffer_unit #(
   parameter int MAX_WIDTH  = abfb_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = abfb_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [abfb_pkg::OP_W-1:0]           req_op,
   input  logic signed [abfb_pkg::COORD_W-1:0] req_x_pos,
   input  logic signed [abfb_pkg::COORD_W-1:0] req_y_pos,
   input  logic signed [abfb_pkg::COORD_W-1:0] req_x_end,
   input  logic signed [abfb_pkg::COORD_W-1:0] req_y_end,
   input  logic [abfb_pkg::PIXEL_W-1:0]        req_pixel_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [abfb_pkg::PIXEL_W-1:0]        rsp_pixel_out,
   output logic                                rsp_in_range,
   input  logic                                csr_we,
   input  logic [abfb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [abfb_pkg::DIM_W-1:0]          csr_wdata
);
   import abfb_pkg::*;

   cmd_type push_cmd;
   cmd_type q_cmd;
   logic    push, pop, q_valid, q_full, clearing;

   abfb_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_op       (req_op),
      .req_x_pos    (req_x_pos),
      .req_y_pos    (req_y_pos),
      .req_x_end    (req_x_end),
      .req_y_end    (req_y_end),
      .req_pixel_in (req_pixel_in),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .q_full       (q_full),
      .clearing     (clearing),
      .push         (push),
      .cmd          (push_cmd)
   );

   abfb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .q_valid  (q_valid),
      .q_full   (q_full),
      .q_cmd    (q_cmd)
   );

   abfb_back #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_cmd         (q_cmd),
      .pop           (pop),
      .clearing      (clearing),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_in_range  (rsp_in_range)
   );

endmodule

// ===== tb/abfb_blend_monitor.sv =====
module abfb_blend_monitor #(
   parameter int MAX_WIDTH  = abfb_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = abfb_pkg::DEF_MAX_HEIGHT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   input  logic                                req_stall,
   input  logic [abfb_pkg::OP_W-1:0]           req_op,
   input  logic signed [abfb_pkg::COORD_W-1:0] req_x_pos,
   input  logic signed [abfb_pkg::COORD_W-1:0] req_y_pos,
   input  logic signed [abfb_pkg::COORD_W-1:0] req_x_end,
   input  logic signed [abfb_pkg::COORD_W-1:0] req_y_end,
   input  logic [abfb_pkg::PIXEL_W-1:0]        req_pixel_in,
   input  logic                                rsp_valid,
   input  logic                                rsp_stall,
   input  logic [abfb_pkg::PIXEL_W-1:0]        rsp_pixel_out,
   input  logic                                rsp_in_range,
   input  logic                                csr_we,
   input  logic [abfb_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [abfb_pkg::DIM_W-1:0]          csr_wdata,
   output int                                  mismatch_count,
   output int                                  pending_count
);

   import abfb_pkg::*;

   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;

   typedef struct packed {
      logic [PIXEL_W-1:0] pixel;
      logic               in_range;
   } pixel_result_type;

   logic [PIXEL_W-1:0] image_copy [STORE_DEPTH];
   logic [DIM_W-1:0]   width_reg;
   logic [DIM_W-1:0]   height_reg;
   pixel_result_type   predicted_pixels [$];

   function automatic logic [PIXEL_W-1:0] blend_over(input logic [PIXEL_W-1:0] back,
                                                     input logic [PIXEL_W-1:0] front);
      logic [CHAN_W-1:0]  a;
      logic [CHAN_W-1:0]  back_a;
      logic [PIXEL_W-1:0] mixed;
      int unsigned        b;
      int unsigned        f;
      int unsigned        c;
      a = front[31:24];
      back_a = back[31:24];
      if (a == 8'd0) return back;
      if (a == 8'd255) return front;
      mixed = '0;
      for (int ch = 0; ch < 3; ch++) begin
         b = back[ch*CHAN_W +: CHAN_W];
         f = front[ch*CHAN_W +: CHAN_W];
         c = (b * (255 - a) + f * a) / 255;
         mixed[ch*CHAN_W +: CHAN_W] = c[CHAN_W-1:0];
      end
      mixed[31:24] = (back_a > a) ? back_a : a;
      return mixed;
   endfunction

   task automatic apply_pixel_op(input logic [OP_W-1:0] op, input int x, input int y,
                                 input int xe, input int ye,
                                 input logic [PIXEL_W-1:0] color,
                                 output pixel_result_type outcome);
      int w;
      int h;
      int idx;
      int x_lo;
      int x_hi;
      int y_lo;
      int y_hi;
      // sizes above the store are clamped, not wrapped
      w = (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
      h = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg);
      outcome = '0;
      case (op)
         OP_WRITE, OP_BLEND, OP_READ: begin
            if (x >= 0 && y >= 0 && x < w && y < h) begin
               idx = (y * w + x) % STORE_DEPTH;
               outcome.in_range = 1'b1;
               if (op == OP_WRITE)
                  image_copy[idx] = color;
               else if (op == OP_BLEND)
                  image_copy[idx] = blend_over(image_copy[idx], color);
               else
                  outcome.pixel = image_copy[idx];
            end
         end
         OP_FILL_ALL: begin
            for (int i = 0; i < w * h && i < STORE_DEPTH; i++)
               image_copy[i] = color;
         end
         OP_FILL_RECT: begin
            x_lo = (x < 0) ? 0 : x;
            y_lo = (y < 0) ? 0 : y;
            x_hi = (xe > w - 1) ? w - 1 : xe;
            y_hi = (ye > h - 1) ? h - 1 : ye;
            for (int row = y_lo; row <= y_hi; row++)
               for (int col = x_lo; col <= x_hi; col++)
                  image_copy[(row * w + col) % STORE_DEPTH] = color;
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : watch
      pixel_result_type oldest;
      pixel_result_type fresh;
      if (reset) begin
         for (int i = 0; i < STORE_DEPTH; i++)
            image_copy[i] = '0;
         width_reg = RESET_DIM;
         height_reg = RESET_DIM;
         predicted_pixels.delete();
         mismatch_count = 0;
         pending_count = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_IMAGE_WIDTH:  width_reg = csr_wdata;
               REG_IMAGE_HEIGHT: height_reg = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && !rsp_stall) begin
            if (predicted_pixels.size() == 0) begin
               $display("%0t: result with nothing expected, pixel_out %h in_range %b",
                        $time, rsp_pixel_out, rsp_in_range);
               mismatch_count++;
            end else begin
               oldest = predicted_pixels.pop_front();
               if (rsp_pixel_out !== oldest.pixel) begin
                  $display("%0t: pixel_out expected %h actual %h",
                           $time, oldest.pixel, rsp_pixel_out);
                  mismatch_count++;
               end
               if (rsp_in_range !== oldest.in_range) begin
                  $display("%0t: in_range expected %b actual %b",
                           $time, oldest.in_range, rsp_in_range);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            apply_pixel_op(req_op, req_x_pos, req_y_pos, req_x_end, req_y_end,
                           req_pixel_in, fresh);
            predicted_pixels.push_back(fresh);
         end
         pending_count = predicted_pixels.size();
      end
   end

endmodule

// ===== tb/tb_alpha_blend_framebuffer_unit.sv =====
module tb_alpha_blend_framebuffer_unit;

   import abfb_pkg::*;

   localparam int PRESSURE_AFTER  = 300;
   localparam int PRESSURE_CYCLES = 400;

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [OP_W-1:0]           req_op;
   logic signed [COORD_W-1:0] req_x_pos;
   logic signed [COORD_W-1:0] req_y_pos;
   logic signed [COORD_W-1:0] req_x_end;
   logic signed [COORD_W-1:0] req_y_end;
   logic [PIXEL_W-1:0]        req_pixel_in;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [PIXEL_W-1:0]        rsp_pixel_out;
   logic                      rsp_in_range;
   logic                      csr_we;
   logic [CSR_INDEX_W-1:0]    csr_index;
   logic [DIM_W-1:0]          csr_wdata;
   int                        mismatch_count;
   int                        pending_count;
   int                        items_sent;
   bit                        gaps_on;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   alpha_blend_framebuffer_unit dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_op        (req_op),
      .req_x_pos     (req_x_pos),
      .req_y_pos     (req_y_pos),
      .req_x_end     (req_x_end),
      .req_y_end     (req_y_end),
      .req_pixel_in  (req_pixel_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_pixel_out (rsp_pixel_out),
      .rsp_in_range  (rsp_in_range),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   abfb_blend_monitor monitor (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_x_pos      (req_x_pos),
      .req_y_pos      (req_y_pos),
      .req_x_end      (req_x_end),
      .req_y_end      (req_y_end),
      .req_pixel_in   (req_pixel_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel_out  (rsp_pixel_out),
      .rsp_in_range   (rsp_in_range),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   // called at a falling edge, returns at a falling edge
   task automatic send_req(input logic [OP_W-1:0] op, input int x, input int y,
                           input int xe, input int ye, input logic [PIXEL_W-1:0] color);
      int r;
      int gap;
      req_op = op;
      req_x_pos = x[COORD_W-1:0];
      req_y_pos = y[COORD_W-1:0];
      req_x_end = xe[COORD_W-1:0];
      req_y_end = ye[COORD_W-1:0];
      req_pixel_in = color;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      req_valid = 1'b0;
      items_sent++;
      if (gaps_on) begin
         r = $urandom_range(0, 99);
         gap = (r < 60) ? 0 : (r < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index, input int value);
      csr_index = index;
      csr_wdata = value[DIM_W-1:0];
      csr_we = 1'b1;
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_count != 0) @(negedge clock);
   endtask

   // mostly inside the image or one step past its edges, sometimes anywhere in the 16-bit range
   function automatic int pick_coord(input int extent);
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return int'($urandom);
      if (r == 1) begin
         case ($urandom_range(0, 3))
            0: return -32768;
            1: return 32767;
            2: return extent;
            default: return extent - 1;
         endcase
      end
      return int'($urandom_range(0, extent + 1)) - 1;
   endfunction

   task automatic run_phase(input int w, input int h, input int count);
      int ew;
      int eh;
      int r;
      int x;
      int y;
      int xe;
      int ye;
      bit roomy;
      logic [OP_W-1:0]    op;
      logic [PIXEL_W-1:0] color;
      wait_drained();
      write_reg(REG_IMAGE_WIDTH, w);
      write_reg(REG_IMAGE_HEIGHT, h);
      gaps_on = ($urandom_range(0, 3) != 0);
      ew = (w > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : w;
      eh = (h > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : h;
      // large images get only small rectangles and no whole-image fill
      roomy = (ew * eh <= 4096);
      repeat (count) begin
         r = $urandom_range(0, 99);
         if (r < 25) op = OP_WRITE;
         else if (r < 50) op = OP_BLEND;
         else if (r < 72) op = OP_READ;
         else if (r < 86) op = OP_FILL_RECT;
         else if (r < 90) op = roomy ? OP_FILL_ALL : OP_READ;
         else op = OP_FILL_RECT + OP_W'($urandom_range(1, 3));
         x = pick_coord(ew);
         y = pick_coord(eh);
         xe = int'($urandom);
         ye = int'($urandom);
         if (op == OP_FILL_RECT && !(roomy && $urandom_range(0, 4) == 0)) begin
            xe = x + int'($urandom_range(0, roomy ? ew : 8)) - 1;
            ye = y + int'($urandom_range(0, roomy ? eh : 8)) - 1;
         end
         color = $urandom;
         r = $urandom_range(0, 9);
         if (r < 2) color[31:24] = 8'h00;
         else if (r < 4) color[31:24] = 8'hFF;
         send_req(op, x, y, xe, ye, color);
      end
   endtask

   initial begin : rsp_side
      int r;
      int stall_len;
      int go_len;
      bit pressure_done;
      rsp_stall = 1'b0;
      pressure_done = 1'b0;
      forever begin
         // one long hold-off so the internal queue fills and backs up the input
         if (!pressure_done && items_sent >= PRESSURE_AFTER) begin
            pressure_done = 1'b1;
            rsp_stall = 1'b1;
            repeat (PRESSURE_CYCLES) @(negedge clock);
         end
         r = $urandom_range(0, 99);
         stall_len = (r < 60) ? 0 : (r < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
         r = $urandom_range(0, 99);
         go_len = (r < 90) ? $urandom_range(1, 8) : $urandom_range(30, 100);
         if (stall_len > 0) begin
            rsp_stall = 1'b1;
            repeat (stall_len) @(negedge clock);
         end
         rsp_stall = 1'b0;
         repeat (go_len) @(negedge clock);
      end
   end

   initial begin
      #200_000_000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_WRITE;
      req_x_pos = '0;
      req_y_pos = '0;
      req_x_end = '0;
      req_y_end = '0;
      req_pixel_in = '0;
      csr_we = 1'b0;
      csr_index = REG_IMAGE_WIDTH;
      csr_wdata = '0;
      items_sent = 0;
      gaps_on = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed part at the reset size of 256 x 256
      send_req(OP_READ, 0, 0, 0, 0, 32'h0000_0000);
      send_req(OP_WRITE, 0, 0, -1, -1, 32'hFFFF_FFFF);
      send_req(OP_WRITE, 255, 255, 32767, -32768, 32'h8040_2010);
      send_req(OP_READ, 0, 0, 0, 0, 32'hFFFF_FFFF);
      send_req(OP_READ, 255, 255, 0, 0, 32'h0000_0000);
      send_req(OP_WRITE, 256, 0, 0, 0, 32'h1111_1111);
      send_req(OP_WRITE, -1, 5, 0, 0, 32'h2222_2222);
      send_req(OP_READ, 32767, -32768, 0, 0, 32'h0000_0000);
      send_req(OP_BLEND, -32768, 32767, 0, 0, 32'h80FF_FFFF);
      // zero alpha keeps the stored pixel, full alpha replaces it
      send_req(OP_BLEND, 255, 255, 0, 0, 32'h00AB_CDEF);
      send_req(OP_READ, 255, 255, 0, 0, 32'h0000_0000);
      send_req(OP_BLEND, 255, 255, 0, 0, 32'hFF11_2233);
      send_req(OP_BLEND, 255, 255, 0, 0, 32'h7F00_FF80);
      send_req(OP_READ, 255, 255, 0, 0, 32'h0000_0000);
      send_req(OP_BLEND, 0, 0, 0, 0, 32'h0100_0000);
      send_req(OP_BLEND, 10, 10, 0, 0, 32'hFEFF_FFFF);
      send_req(OP_READ, 0, 0, 0, 0, 32'h0000_0000);
      send_req(OP_READ, 10, 10, 0, 0, 32'h0000_0000);
      send_req(OP_FILL_RECT, -5, 250, 3, 300, 32'h5A5A_A5A5);
      send_req(OP_READ, 0, 255, 0, 0, 32'h0000_0000);
      send_req(OP_FILL_RECT, 10, 10, 5, 20, 32'h3C3C_3C3C);
      send_req(OP_FILL_RECT, -32768, -32768, -1, 32767, 32'h7777_7777);
      for (int k = 1; k <= 3; k++)
         send_req(OP_FILL_RECT + OP_W'(k), 3, 3, 4, 4, 32'h9999_9999);
      send_req(OP_FILL_ALL, 0, 0, 0, 0, 32'hC0FF_EE00);
      send_req(OP_READ, 128, 77, 0, 0, 32'h0000_0000);

      run_phase(1, 1, 100);
      run_phase(0, 6, 40);
      run_phase(6, 0, 40);
      run_phase(511, 511, 140);
      run_phase(300, 3, 140);
      run_phase(16, 16, 140);
      run_phase(3, 200, 140);
      run_phase(256, 1, 140);
      run_phase(1, 256, 140);
      run_phase(40, 40, 140);
      run_phase(2, 3, 120);
      repeat (3) run_phase($urandom_range(1, 24), $urandom_range(1, 24), 120);

      wait_drained();
      repeat (20) @(negedge clock);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
